/* rtl/ssg_pkg.sv */
`default_nettype none

package ssg_pkg;

    localparam int WINDOW_FRAMES = 16;
    localparam int TAG_BITS      = 16;
    localparam int THR_BITS      = 5;
    localparam int THR_RESET     = 14;

    localparam int IDX_W   = (WINDOW_FRAMES > 1) ? $clog2(WINDOW_FRAMES) : 1;
    localparam int CNT_W   = $clog2(WINDOW_FRAMES + 1);
    localparam int CMP_W   = (CNT_W > THR_BITS) ? CNT_W : THR_BITS;
    localparam int TDATA_W = ((TAG_BITS + 7) / 8) * 8;

    typedef enum logic [1:0] {
        KIND_VOICE = 2'd0,
        KIND_START = 2'd1,
        KIND_END   = 2'd2
    } t_kind;

    // window control from the sequencer
    typedef struct packed {
        logic             push;
        logic             flag;
        logic             clear;
        logic             rd_en;
        logic [IDX_W-1:0] rd_off;
    } t_win_ctl;

    typedef struct packed {
        logic [CNT_W-1:0] fill;
        logic [CNT_W-1:0] count;
    } t_win_sts;

    // (base + off) mod WINDOW_FRAMES, base < WINDOW_FRAMES, off <= WINDOW_FRAMES
    function automatic logic [IDX_W-1:0] ptr_add(input logic [IDX_W-1:0] base,
                                                 input logic [CNT_W-1:0] off);
        logic [CNT_W:0] s;
        s = (CNT_W+1)'(base) + (CNT_W+1)'(off);
        if (s >= (CNT_W+1)'(WINDOW_FRAMES)) begin
            s = s - (CNT_W+1)'(WINDOW_FRAMES);
        end
        return s[IDX_W-1:0];
    endfunction

endpackage

`default_nettype wire

/* rtl/ssg_window.sv */
`default_nettype none

module ssg_window (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  ssg_pkg::t_win_ctl                i_ctl,
    input  wire  [ssg_pkg::TAG_BITS-1:0]     i_tag,
    output ssg_pkg::t_win_sts                o_sts,
    output logic [ssg_pkg::TAG_BITS-1:0]     o_rd_tag
);

    logic [ssg_pkg::TAG_BITS-1:0]      r_mem [ssg_pkg::WINDOW_FRAMES];
    logic [ssg_pkg::WINDOW_FRAMES-1:0] r_flags;
    logic [ssg_pkg::TAG_BITS-1:0]      r_rd_tag;
    logic [ssg_pkg::CNT_W-1:0]         r_fill;
    logic [ssg_pkg::CNT_W-1:0]         r_count;
    logic [ssg_pkg::IDX_W-1:0]         r_head;

    logic [ssg_pkg::CNT_W-1:0] w_off;
    logic [ssg_pkg::IDX_W-1:0] w_addr;
    logic                      w_full;

    assign w_full = (r_fill == ssg_pkg::CNT_W'(ssg_pkg::WINDOW_FRAMES));
    // one address adder shared by the push slot and the replay read
    assign w_off  = i_ctl.push ? (w_full ? '0 : r_fill) : ssg_pkg::CNT_W'(i_ctl.rd_off);
    assign w_addr = ssg_pkg::ptr_add(r_head, w_off);

    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_mem[w_addr]   <= i_tag;
            r_flags[w_addr] <= i_ctl.flag;
        end
        if (i_ctl.rd_en) begin
            r_rd_tag <= r_mem[w_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill  <= '0;
            r_count <= '0;
            r_head  <= '0;
        end else if (i_ctl.clear) begin
            r_fill  <= '0;
            r_count <= '0;
            r_head  <= '0;
        end else if (i_ctl.push) begin
            if (w_full) begin
                // oldest entry drops out
                r_count <= r_count + ssg_pkg::CNT_W'(i_ctl.flag)
                           - ssg_pkg::CNT_W'(r_flags[r_head]);
                r_head  <= ssg_pkg::ptr_add(r_head, ssg_pkg::CNT_W'(1));
            end else begin
                r_fill  <= r_fill + ssg_pkg::CNT_W'(1);
                r_count <= r_count + ssg_pkg::CNT_W'(i_ctl.flag);
            end
        end
    end

    assign o_sts.fill  = r_fill;
    assign o_sts.count = r_count;
    assign o_rd_tag    = r_rd_tag;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= ssg_pkg::CNT_W'(ssg_pkg::WINDOW_FRAMES))
        else $error("window fill above window length");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= r_fill)
        else $error("voiced count above fill");

    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.clear |=> (r_fill == '0 && r_count == '0))
        else $error("window not empty after clear");

endmodule

`default_nettype wire

/* rtl/speech_segment_gate_top.sv */
`default_nettype none

// Speech segment gate.
// Input stream: s_axis_tdata carries the frame tag, s_axis_tuser[0] the voiced
// flag. Output stream: m_axis_tdata carries the frame tag (zero for events),
// m_axis_tuser the result kind (voice frame, speech start, segment end), and
// m_axis_tlast marks the final result caused by one input frame.
// Config channel i_cfg_valid/o_cfg_ready/i_cfg_data writes the trigger
// threshold; write it only while the block is idle.
// One frame is handled at a time through a small sequencer: transfer, window
// push, threshold check, then results. A trigger replays every buffered frame,
// oldest first. The replay rate is one tag per cycle from the registered read
// port of the tag store while the output register is free. Results leave
// through a single output register; while the receiver stalls the sequencer
// waits and s_axis_tready stays low until the frame's last result is loaded.
// Synchronous reset empties the window, returns to idle and sets the
// threshold to 14.

module speech_segment_gate_top (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               s_axis_tvalid,
    output logic                              s_axis_tready,
    input  wire  [ssg_pkg::TDATA_W-1:0]       s_axis_tdata,  // frame_tag
    input  wire  [0:0]                        s_axis_tuser,  // voiced
    output logic                              m_axis_tvalid,
    input  wire                               m_axis_tready,
    output logic [ssg_pkg::TDATA_W-1:0]       m_axis_tdata,  // out_tag
    output logic [1:0]                        m_axis_tuser,  // result_kind
    output logic                              m_axis_tlast,
    input  wire                               i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire  [ssg_pkg::THR_BITS-1:0]      i_cfg_data
);

    typedef enum logic [2:0] {
        ST_IN,
        ST_PUSH,
        ST_CHECK,
        ST_VOICE,
        ST_END,
        ST_START,
        ST_REPLAY
    } t_state;

    t_state                          r_state;
    logic                            r_active;
    logic                            r_end;
    logic [ssg_pkg::THR_BITS-1:0]    r_thr;
    logic [ssg_pkg::TAG_BITS-1:0]    r_tag;
    logic                            r_flag;
    logic [ssg_pkg::IDX_W-1:0]       r_idx;
    logic                            r_ov;
    ssg_pkg::t_kind                  r_okind;
    logic [ssg_pkg::TAG_BITS-1:0]    r_otag;
    logic                            r_olast;

    ssg_pkg::t_win_ctl               w_ctl;
    ssg_pkg::t_win_sts               w_sts;
    logic [ssg_pkg::TAG_BITS-1:0]    w_rd_tag;
    logic                            w_out_free;
    logic                            w_load;
    logic                            w_start_hit;
    logic                            w_end_hit;
    logic                            w_rep_last;
    logic [ssg_pkg::CMP_W-1:0]       w_thr_x;

    ssg_window u_window (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ctl),
        .i_tag    (r_tag),
        .o_sts    (w_sts),
        .o_rd_tag (w_rd_tag)
    );

    assign w_out_free  = !r_ov || m_axis_tready;
    // output register takes a new result in every result state once free
    assign w_load      = w_out_free && (r_state inside {ST_VOICE, ST_END, ST_START, ST_REPLAY});
    assign w_thr_x     = ssg_pkg::CMP_W'(r_thr);
    assign w_start_hit = ssg_pkg::CMP_W'(w_sts.count) > w_thr_x;
    assign w_end_hit   = ssg_pkg::CMP_W'(w_sts.fill - w_sts.count) > w_thr_x;
    assign w_rep_last  = (ssg_pkg::CNT_W'(r_idx) + ssg_pkg::CNT_W'(1)) == w_sts.fill;

    always_comb begin
        w_ctl        = '0;
        w_ctl.flag   = r_flag;
        w_ctl.rd_off = r_idx + ssg_pkg::IDX_W'(1);
        case (r_state)
            ST_PUSH: begin
                w_ctl.push = 1'b1;
            end
            ST_START: begin
                w_ctl.rd_en  = w_out_free;
                w_ctl.rd_off = '0;
            end
            ST_REPLAY: begin
                w_ctl.rd_en = w_out_free && !w_rep_last;
                w_ctl.clear = w_out_free && w_rep_last;
            end
            ST_END: begin
                w_ctl.clear = w_out_free;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IN;
            r_active <= 1'b0;
            r_end    <= 1'b0;
            r_thr    <= ssg_pkg::THR_BITS'(ssg_pkg::THR_RESET);
            r_idx    <= '0;
            r_ov     <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_thr <= i_cfg_data;
            end
            if (w_load) begin
                r_ov <= 1'b1;
            end else if (m_axis_tready) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                ST_IN: begin
                    if (s_axis_tvalid) begin
                        r_tag   <= s_axis_tdata[ssg_pkg::TAG_BITS-1:0];
                        r_flag  <= s_axis_tuser[0];
                        r_state <= ST_PUSH;
                    end
                end
                ST_PUSH: begin
                    r_state <= ST_CHECK;
                end
                ST_CHECK: begin
                    if (r_active) begin
                        r_end   <= w_end_hit;
                        r_state <= ST_VOICE;
                    end else if (w_start_hit) begin
                        r_state <= ST_START;
                    end else begin
                        r_state <= ST_IN;
                    end
                end
                ST_VOICE: begin
                    if (w_out_free) begin
                        r_okind <= ssg_pkg::KIND_VOICE;
                        r_otag  <= r_tag;
                        r_olast <= !r_end;
                        r_state <= r_end ? ST_END : ST_IN;
                    end
                end
                ST_END: begin
                    if (w_out_free) begin
                        r_okind  <= ssg_pkg::KIND_END;
                        r_otag   <= '0;
                        r_olast  <= 1'b1;
                        r_active <= 1'b0;
                        r_state  <= ST_IN;
                    end
                end
                ST_START: begin
                    if (w_out_free) begin
                        r_okind <= ssg_pkg::KIND_START;
                        r_otag  <= '0;
                        r_olast <= 1'b0;
                        r_idx   <= '0;
                        r_state <= ST_REPLAY;
                    end
                end
                ST_REPLAY: begin
                    if (w_out_free) begin
                        r_okind <= ssg_pkg::KIND_VOICE;
                        r_otag  <= w_rd_tag;
                        r_olast <= w_rep_last;
                        r_idx   <= r_idx + ssg_pkg::IDX_W'(1);
                        if (w_rep_last) begin
                            r_active <= 1'b1;
                            r_state  <= ST_IN;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IN;
                end
            endcase
        end
    end

    assign s_axis_tready = (r_state == ST_IN);
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = ssg_pkg::TDATA_W'(r_otag);
    assign m_axis_tuser  = r_okind;
    assign m_axis_tlast  = r_olast;

    a_one_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("second frame taken while one is in work");

    a_start_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == ssg_pkg::KIND_START) |-> !m_axis_tlast)
        else $error("speech start marked last");

    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == ssg_pkg::KIND_END) |-> (m_axis_tlast && !r_active))
        else $error("segment end not last or still active");

    a_replay_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_START) |-> (w_sts.fill != '0))
        else $error("speech start with empty window");

endmodule

`default_nettype wire

/* tb/testbench.sv */
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DIR_ROWS     = 24;
    localparam int RAND_PHASES  = 9;
    localparam int PHASE_FRAMES = 32;
    localparam int SETTLE_CYC   = 30;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int MAX_RES      = ssg_pkg::WINDOW_FRAMES + 2;
    localparam int EXP_DEPTH    = 256;

    // how a directed row's results are expected: from the predictor, or typed in
    typedef enum {SHAPE_PREDICT, SHAPE_NONE, SHAPE_PASS, SHAPE_PASS_END} t_row_shape;

    typedef struct {
        int                           thr;     // -1: keep the current threshold
        logic [ssg_pkg::TAG_BITS-1:0] tag;
        logic                         voiced;
        t_row_shape                   shape;
    } t_dir_row;

    typedef struct packed {
        ssg_pkg::t_kind               kind;
        logic [ssg_pkg::TAG_BITS-1:0] tag;
        logic                         last;
    } t_gate_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic                         s_axis_tvalid = 1'b0;
    wire                          s_axis_tready;
    logic [ssg_pkg::TDATA_W-1:0]  s_axis_tdata = '0;   // frame_tag
    logic [0:0]                   s_axis_tuser = '0;   // voiced
    wire                          m_axis_tvalid;
    logic                         m_axis_tready = 1'b0;
    wire  [ssg_pkg::TDATA_W-1:0]  m_axis_tdata;        // out_tag
    wire  [1:0]                   m_axis_tuser;        // result_kind
    wire                          m_axis_tlast;
    logic                         i_cfg_valid = 1'b0;
    wire                          o_cfg_ready;
    logic [ssg_pkg::THR_BITS-1:0] i_cfg_data = '0;

    speech_segment_gate_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // gate model state
    logic [ssg_pkg::TAG_BITS-1:0] win_tag [ssg_pkg::WINDOW_FRAMES];
    bit                           win_flag [ssg_pkg::WINDOW_FRAMES];
    int unsigned                  win_fill = 0;
    int unsigned                  win_head = 0;
    int unsigned                  voiced_cnt = 0;
    bit                           in_speech = 1'b0;
    int unsigned                  gate_thr = ssg_pkg::THR_RESET;

    // results of one frame, and the ring of results still to arrive
    t_gate_result frame_res [MAX_RES];
    int           frame_cnt = 0;
    t_gate_result exp_buf [EXP_DEPTH];
    int           exp_wr = 0;
    int           exp_rd = 0;

    t_dir_row     dir_rows [DIR_ROWS];
    int           dir_cnt = 0;

    int send_idle_pct = 26;
    int recv_idle_pct = 63;
    int err_cnt = 0;
    int frames_sent = 0;
    int results_seen = 0;
    int starts_seen = 0;
    int ends_seen = 0;
    int thr_writes = 0;
    int cycle_cnt = 0;

    function automatic void frame_add(ssg_pkg::t_kind kind,
                                      logic [ssg_pkg::TAG_BITS-1:0] tag);
        frame_res[frame_cnt].kind = kind;
        frame_res[frame_cnt].tag  = tag;
        frame_res[frame_cnt].last = 1'b0;
        frame_cnt++;
    endfunction

    function automatic void exp_put(ssg_pkg::t_kind kind,
                                    logic [ssg_pkg::TAG_BITS-1:0] tag, logic last);
        exp_buf[exp_wr % EXP_DEPTH].kind = kind;
        exp_buf[exp_wr % EXP_DEPTH].tag  = tag;
        exp_buf[exp_wr % EXP_DEPTH].last = last;
        exp_wr++;
    endfunction

    function automatic int exp_pending();
        return exp_wr - exp_rd;
    endfunction

    function automatic void add_row(int thr, logic [ssg_pkg::TAG_BITS-1:0] tag,
                                    logic voiced, t_row_shape shape);
        dir_rows[dir_cnt].thr    = thr;
        dir_rows[dir_cnt].tag    = tag;
        dir_rows[dir_cnt].voiced = voiced;
        dir_rows[dir_cnt].shape  = shape;
        dir_cnt++;
    endfunction

    function automatic void window_push(logic [ssg_pkg::TAG_BITS-1:0] tag, bit flag);
        int unsigned slot;
        if (win_fill < ssg_pkg::WINDOW_FRAMES) begin
            slot = (win_head + win_fill) % ssg_pkg::WINDOW_FRAMES;
            win_fill++;
        end else begin
            slot = win_head;
            voiced_cnt -= win_flag[slot];
            win_head = (win_head + 1) % ssg_pkg::WINDOW_FRAMES;
        end
        win_tag[slot] = tag;
        win_flag[slot] = flag;
        voiced_cnt += flag;
    endfunction

    function automatic void window_clear();
        win_fill = 0;
        win_head = 0;
        voiced_cnt = 0;
    endfunction

    // fills frame_res with what one frame causes and advances the state
    function automatic void predict_frame(logic [ssg_pkg::TAG_BITS-1:0] tag, bit flag);
        frame_cnt = 0;
        if (!in_speech) begin
            window_push(tag, flag);
            if (voiced_cnt > gate_thr) begin
                frame_add(ssg_pkg::KIND_START, '0);
                // replay oldest first
                for (int i = 0; i < win_fill; i++) begin
                    frame_add(ssg_pkg::KIND_VOICE,
                              win_tag[(win_head + i) % ssg_pkg::WINDOW_FRAMES]);
                end
                window_clear();
                in_speech = 1'b1;
            end
        end else begin
            frame_add(ssg_pkg::KIND_VOICE, tag);
            window_push(tag, flag);
            if (win_fill - voiced_cnt > gate_thr) begin
                frame_add(ssg_pkg::KIND_END, '0);
                window_clear();
                in_speech = 1'b0;
            end
        end
        if (frame_cnt > 0) begin
            frame_res[frame_cnt - 1].last = 1'b1;
        end
    endfunction

    task automatic send_frame(input logic [ssg_pkg::TAG_BITS-1:0] tag, input logic voiced,
                              input t_row_shape shape);
        if ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= tag;
        s_axis_tuser  <= voiced;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_frame(tag, voiced);
        case (shape)
            SHAPE_PREDICT: begin
                for (int i = 0; i < frame_cnt; i++) begin
                    exp_put(frame_res[i].kind, frame_res[i].tag, frame_res[i].last);
                end
            end
            SHAPE_PASS: begin
                exp_put(ssg_pkg::KIND_VOICE, tag, 1'b1);
            end
            SHAPE_PASS_END: begin
                exp_put(ssg_pkg::KIND_VOICE, tag, 1'b0);
                exp_put(ssg_pkg::KIND_END, '0, 1'b1);
            end
            default: begin
            end
        endcase
        frames_sent++;
    endtask

    // only while the sequencer is quiet: drain results, then let it settle
    task automatic write_threshold(input int thr);
        s_axis_tvalid <= 1'b0;
        while (exp_pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= thr[ssg_pkg::THR_BITS-1:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        gate_thr = thr;
        thr_writes++;
    endtask

    // result checker and receiver stalls
    always @(posedge i_clk) begin
        t_gate_result want;
        if (i_rst_n && m_axis_tvalid === 1'b1 && m_axis_tready) begin
            results_seen++;
            if (m_axis_tuser == ssg_pkg::KIND_START) starts_seen++;
            if (m_axis_tuser == ssg_pkg::KIND_END) ends_seen++;
            if (exp_pending() == 0) begin
                $error("unexpected result: result_kind %0d out_tag %h last %b",
                       m_axis_tuser, m_axis_tdata, m_axis_tlast);
                err_cnt++;
            end else begin
                want = exp_buf[exp_rd % EXP_DEPTH];
                exp_rd++;
                if (m_axis_tuser !== want.kind) begin
                    $error("result_kind: expected %0d, got %0d", want.kind, m_axis_tuser);
                    err_cnt++;
                end
                if (m_axis_tdata !== want.tag) begin
                    $error("out_tag: expected %h, got %h", want.tag, m_axis_tdata);
                    err_cnt++;
                end
                if (m_axis_tlast !== want.last) begin
                    $error("last: expected %b, got %b", want.last, m_axis_tlast);
                    err_cnt++;
                end
            end
        end
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_cnt, exp_pending());
            $display("speech_segment_gate_top regression: fail");
            $finish;
        end
    end

    initial begin
        int          thr;
        int          sent;
        int          run_len;
        int          voice_pct;
        int          phase_thr[RAND_PHASES];

        // reset threshold first, then zero (window is not cleared by the write),
        // then equal to window length, then the highest one that can still fire
        add_row(-1, 16'h0000, 1'b1, SHAPE_NONE);
        add_row(-1, 16'hFFFF, 1'b0, SHAPE_NONE);
        add_row( 0, 16'h1234, 1'b0, SHAPE_PREDICT);
        add_row(-1, 16'hA5A5, 1'b1, SHAPE_PASS);
        add_row(-1, 16'h5A5A, 1'b0, SHAPE_PASS_END);
        add_row(-1, 16'h8000, 1'b0, SHAPE_NONE);
        add_row(-1, 16'h0001, 1'b1, SHAPE_PREDICT);
        add_row(-1, 16'h7FFF, 1'b0, SHAPE_PASS_END);
        add_row(16, 16'hFFFF, 1'b1, SHAPE_NONE);
        add_row(-1, 16'h0002, 1'b1, SHAPE_NONE);
        add_row(-1, 16'h0004, 1'b1, SHAPE_NONE);
        add_row(-1, 16'h0008, 1'b1, SHAPE_NONE);
        add_row(15, 16'h0010, 1'b1, SHAPE_NONE);
        for (int i = 0; i < 10; i++) begin
            add_row(-1, 16'h0020 << i, 1'b1, SHAPE_NONE);
        end
        add_row(-1, 16'hC3C3, 1'b1, SHAPE_PREDICT);  // full window fires

        phase_thr = '{0, 14, 3, 16, 8, 1, 12, 15, -1};

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < dir_cnt; r++) begin
            if (dir_rows[r].thr >= 0) write_threshold(dir_rows[r].thr);
            send_frame(dir_rows[r].tag, dir_rows[r].voiced, dir_rows[r].shape);
        end

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            case (ph / 3)
                0: begin
                    send_idle_pct = 26;
                    recv_idle_pct = 63;
                end
                1: begin
                    send_idle_pct = 63;
                    recv_idle_pct = 26;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            thr = (phase_thr[ph] < 0) ? int'($urandom_range(16)) : phase_thr[ph];
            write_threshold(thr);
            sent = 0;
            // talk spurts and pauses, with an occasional stretch of noise
            while (sent < PHASE_FRAMES) begin
                run_len = $urandom_range(24, 4);
                case ($urandom_range(5))
                    0:       voice_pct = 50;
                    1, 2:    voice_pct = 12;
                    default: voice_pct = 88;
                endcase
                for (int k = 0; k < run_len && sent < PHASE_FRAMES; k++) begin
                    send_frame(ssg_pkg::TAG_BITS'($urandom()),
                               $urandom_range(99) < voice_pct, SHAPE_PREDICT);
                    sent++;
                end
            end
        end

        s_axis_tvalid <= 1'b0;
        while (exp_pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
        if (exp_pending() != 0) begin
            $error("%0d results never arrived", exp_pending());
            err_cnt++;
        end

        $display("%0d frames in, %0d results out (%0d speech starts, %0d segment ends),",
                 frames_sent, results_seen, starts_seen, ends_seen);
        $display("%0d threshold writes across three stall patterns, %0d mismatches",
                 thr_writes, err_cnt);
        if (err_cnt == 0) begin
            $display("speech_segment_gate_top regression: pass");
        end else begin
            $display("speech_segment_gate_top regression: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire

/* filelist.f */
rtl/ssg_pkg.sv
rtl/ssg_window.sv
rtl/speech_segment_gate_top.sv
tb/testbench.sv
